### sv/bzram_pkg.sv
// ----------------------------------------------------------------------------
// bzram_pkg: shared definitions for the banked zone ram unit
// Access kinds, size codes, attribute register roles and default geometry.
// ----------------------------------------------------------------------------
package bzram_pkg;

  // access kind carried on in_tuser
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // access size codes, the unused code behaves as a word
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  // default geometry
  localparam int NUM_BANKS_DEF      = 4;
  localparam int WORDS_PER_BANK_DEF = 128;

  // ram area holds at most this many word rows (offsets 0x200-0x3ff)
  localparam int RAM_ROWS_MAX = 128;

  // attribute registers
  localparam int ATTR_COUNT    = 8;
  localparam int ATTR_BANK_WEN = 4;  // bit 4*b low lets writes reach bank b
  localparam int ATTR_BANK_SEL = 5;  // bits 1:0 pick the bank for reads

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

endpackage

### sv/banked_zone_ram_with_attr_regs_unit.sv
// ----------------------------------------------------------------------------
// banked_zone_ram_with_attr_regs_unit: banked zone ram with attribute regs
// Big-endian bus access unit with eight 16-bit attribute registers and
// NUM_BANKS banks of word ram behind one 1 KB window.
// ----------------------------------------------------------------------------
// Usage:
//   One bus access enters on the in_ stream (in_tuser = read/write kind,
//   in_tdata = offset, size and write data) and one result item leaves on
//   the out_ stream (out_tdata = read data, out_tuser = unmapped flag).
//   Every access, read or write, produces exactly one result item.
//   Latency: the result is valid the cycle after the access is accepted.
//   Throughput: one access per cycle; the bank memories, attribute
//   registers and row valid bits are all updated at the accept edge, and
//   the bank read data is registered at that same edge.
//   When the receiver stalls, the result register holds and in_tready
//   drops until the result is taken (in_tready = !out_tvalid | out_tready).
//   Reset (rst_n low, synchronous) clears the attribute registers, the
//   result valid flag and one valid bit per ram row; a row that was never
//   written reads as zero, and its first write fills the whole row across
//   all banks, so no clearing pass is needed and the unit is ready at once.
// ----------------------------------------------------------------------------
module banked_zone_ram_with_attr_regs_unit #(
  parameter int NUM_BANKS      = bzram_pkg::NUM_BANKS_DEF,
  parameter int WORDS_PER_BANK = bzram_pkg::WORDS_PER_BANK_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bzram_pkg::IN_TDATA_W-1:0] in_tdata,   // offset[9:0], size_code[11:10],
                                                       // write_data[43:12], zero fill
  input  logic [0:0]                       in_tuser,   // op
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bzram_pkg::OUT_TDATA_W-1:0] out_tdata, // read_data[31:0]
  output logic [0:0]                       out_tuser   // unmapped
);

  localparam int IDX_W = $clog2(WORDS_PER_BANK);

  // input fields
  logic        in_op;
  logic [9:0]  in_off;
  logic [1:0]  in_size;
  logic [31:0] in_wd;
  logic        in_acc;

  assign in_op   = in_tuser[0];
  assign in_off  = in_tdata[9:0];
  assign in_size = in_tdata[11:10];
  assign in_wd   = in_tdata[43:12];
  assign in_acc  = in_tvalid && in_tready;

  // access decode
  logic [9:0]  off_al;
  logic [3:0]  be;
  logic [1:0]  shb;
  logic [31:0] wd_m;
  logic [31:0] wsh;
  logic [31:0] lane_mask;
  logic        hit_attr;
  logic        hit_ram;
  logic        unm;

  always_comb begin
    off_al = in_off;
    be     = 4'hf;
    shb    = 2'd0;
    wd_m   = in_wd;
    unique case (in_size)
      bzram_pkg::SIZE_BYTE: begin
        be   = 4'b1000 >> in_off[1:0];
        shb  = 2'd3 - in_off[1:0];
        wd_m = {24'd0, in_wd[7:0]};
      end
      bzram_pkg::SIZE_HALF: begin
        off_al[0] = 1'b0;
        be        = in_off[1] ? 4'b0011 : 4'b1100;
        shb       = in_off[1] ? 2'd0 : 2'd2;
        wd_m      = {16'd0, in_wd[15:0]};
      end
      default: begin
        off_al[1:0] = 2'b00;
      end
    endcase
    wsh       = wd_m << {shb, 3'b000};
    lane_mask = {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    hit_attr  = (in_off[9:4] == 6'd0);
    hit_ram   = in_off[9];
    unm       = !hit_attr && !hit_ram;
  end

  // attribute registers, kept as four big-endian pairs (reg 2k high half)
  logic [3:0][31:0] attr_pair_r;
  logic [15:0]      attr_v [bzram_pkg::ATTR_COUNT];
  logic [1:0]       pair_idx;

  assign pair_idx = off_al[3:2];

  for (genvar i = 0; i < bzram_pkg::ATTR_COUNT; i++) begin : g_attr_view
    if (i % 2 == 0) begin : g_hi
      assign attr_v[i] = attr_pair_r[i / 2][31:16];
    end else begin : g_lo
      assign attr_v[i] = attr_pair_r[i / 2][15:0];
    end
  end

  // attribute write merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_pair_r <= '0;
    end else if (in_acc && (in_op == bzram_pkg::OP_WRITE) && hit_attr) begin
      for (int j = 0; j < 4; j++) begin
        if (be[j]) begin
          attr_pair_r[pair_idx][8*j +: 8] <= wsh[8*j +: 8];
        end
      end
    end
  end

  // row index within a bank, wrapped by a constant table
  logic [IDX_W-1:0] row_tab [bzram_pkg::RAM_ROWS_MAX];
  logic [IDX_W-1:0] row;

  for (genvar i = 0; i < bzram_pkg::RAM_ROWS_MAX; i++) begin : g_row_tab
    assign row_tab[i] = IDX_W'(i % WORDS_PER_BANK);
  end

  assign row = row_tab[off_al[8:2]];

  // bank control from attribute registers
  logic [1:0]           rd_bank;
  logic                 bank_ok;
  logic [NUM_BANKS-1:0] bank_wen;

  assign rd_bank = attr_v[bzram_pkg::ATTR_BANK_SEL][1:0];
  assign bank_ok = (3'(rd_bank) < 3'(NUM_BANKS));

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank_wen
    assign bank_wen[b] = !attr_v[bzram_pkg::ATTR_BANK_WEN][4*b];
  end

  // row valid bits, an unwritten row reads as zero
  logic [WORDS_PER_BANK-1:0] row_valid_r;
  logic                      ram_wr;
  logic                      row_vld;

  assign ram_wr  = in_acc && (in_op == bzram_pkg::OP_WRITE) && hit_ram;
  assign row_vld = row_valid_r[row];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (ram_wr) begin
      row_valid_r[row] <= 1'b1;
    end
  end

  // bank memories with byte lane writes and registered read
  logic [31:0] bank_q_r [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [31:0] mem [WORDS_PER_BANK];
    logic [3:0]  wen;
    logic [31:0] wdat;

    // first write to a row fills every lane of every bank
    always_comb begin
      if (row_vld) begin
        wen  = bank_wen[b] ? be : 4'h0;
        wdat = wsh;
      end else begin
        wen  = 4'hf;
        wdat = bank_wen[b] ? (wsh & lane_mask) : 32'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (ram_wr) begin
        for (int j = 0; j < 4; j++) begin
          if (wen[j]) begin
            mem[row][8*j +: 8] <= wdat[8*j +: 8];
          end
        end
      end
      if (in_acc) begin
        bank_q_r[b] <= mem[row];
      end
    end
  end

  // result register
  logic        out_valid_r;
  logic        op_r;
  logic        unm_r;
  logic        ram_r;
  logic        row_ok_r;
  logic [1:0]  bank_r;
  logic [1:0]  shb_r;
  logic [1:0]  size_r;
  logic [31:0] attr_q_r;

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      unm_r    <= unm;
      ram_r    <= hit_ram;
      row_ok_r <= row_vld && bank_ok;
      bank_r   <= rd_bank;
      shb_r    <= shb;
      size_r   <= in_size;
      attr_q_r <= attr_pair_r[pair_idx];
    end
  end

  // read data alignment
  logic [31:0] bank_sel;
  logic [31:0] raw;
  logic [31:0] shifted;
  logic [31:0] rd;

  always_comb begin
    bank_sel = 32'd0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (bank_r == 2'(b)) begin
        bank_sel = bank_q_r[b];
      end
    end
    if (ram_r) begin
      raw = row_ok_r ? bank_sel : 32'd0;
    end else begin
      raw = attr_q_r;
    end
    shifted = raw >> {shb_r, 3'b000};
    unique case (size_r)
      bzram_pkg::SIZE_BYTE: rd = {24'd0, shifted[7:0]};
      bzram_pkg::SIZE_HALF: rd = {16'd0, shifted[15:0]};
      default:              rd = shifted;
    endcase
    if ((op_r == bzram_pkg::OP_WRITE) || unm_r) begin
      rd = 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rd;
  assign out_tuser  = unm_r;

  // assertions
  a_reset_rows: assert property (@(posedge clk) !rst_n |=> (row_valid_r == '0))
    else $error("row valid bits not cleared by reset");

  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr |=> row_valid_r[$past(row)])
    else $error("written ram row not marked valid");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("unmapped item carries nonzero read data");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted item produced no result");

endmodule

### bench/banked_zone_ram_with_attr_regs_unit_test.sv
// ----------------------------------------------------------------------------
// banked_zone_ram_with_attr_regs_unit_test: stream test of the banked zone ram
// Drives big-endian bus accesses into the attribute registers, the bank ram
// and the unmapped gaps, under random sender gaps and receiver stalls. Each result
// item is checked against a pinned value or a local model of registers and banks.
// ----------------------------------------------------------------------------
module banked_zone_ram_with_attr_regs_unit_test;

  localparam int          RANDOM_ITEMS = 1800;
  localparam int          CALM_ITEMS   = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [9:0]  ATTR_END     = 10'h010;
  localparam logic [9:0]  RAM_BASE     = 10'h200;

  typedef struct packed {
    logic [31:0] read_data;
    logic        unmapped;
  } access_result_t;

  // one directed access, with its result pinned where it is obvious
  typedef struct packed {
    logic        op;
    logic [9:0]  offset;
    logic [1:0]  size_code;
    logic [31:0] write_data;
    logic        pinned;
    logic [31:0] pin_data;
    logic        pin_unmapped;
  } stim_row_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [bzram_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]                        in_tuser   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [bzram_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                        out_tuser;

  // model of the unit's stores
  logic [15:0] attr_q [bzram_pkg::ATTR_COUNT] = '{default: '0};
  logic [31:0] ram_q [bzram_pkg::NUM_BANKS_DEF][bzram_pkg::WORDS_PER_BANK_DEF] =
    '{default: '{default: '0}};

  access_result_t access_results_due [$];

  bit sender_idle = 1'b1;
  bit sink_idle   = 1'b1;
  int stall_left  = 0;
  int cycle_count = 0;
  int mismatches  = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_outside   = 0;
  int n_checked   = 0;

  stim_row_t directed_rows [25] = '{
    // reads right after reset
    '{bzram_pkg::OP_READ,  10'h000, bzram_pkg::SIZE_WORD, 32'h0,        1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h3FC, bzram_pkg::SIZE_WORD, 32'h0,        1'b1, 32'h0, 1'b0},
    // gap between the areas, misaligned word just below the ram
    '{bzram_pkg::OP_READ,  10'h100, bzram_pkg::SIZE_BYTE, 32'h0,        1'b1, 32'h0, 1'b1},
    '{bzram_pkg::OP_WRITE, 10'h010, bzram_pkg::SIZE_WORD, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b1},
    '{bzram_pkg::OP_WRITE, 10'h1FF, bzram_pkg::SIZE_WORD, 32'h12345678, 1'b1, 32'h0, 1'b1},
    // attribute word write, then a size three read of registers 6 and 7
    '{bzram_pkg::OP_WRITE, 10'h000, bzram_pkg::SIZE_WORD, 32'hFFFFFFFF, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h00E, bzram_pkg::SIZE_RSVD, 32'h0,        1'b0, 32'h0, 1'b0},
    // mask banks 1 and 2, excess write data above the access size
    '{bzram_pkg::OP_WRITE, 10'h008, bzram_pkg::SIZE_HALF, 32'hFFFF0110, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_WRITE, 10'h200, bzram_pkg::SIZE_WORD, 32'hA5A5A5A5, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_WRITE, 10'h3FF, bzram_pkg::SIZE_BYTE, 32'h000001FF, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_WRITE, 10'h3FD, bzram_pkg::SIZE_HALF, 32'hFFFF1234, 1'b1, 32'h0, 1'b0},
    // read back from bank 3
    '{bzram_pkg::OP_WRITE, 10'h00A, bzram_pkg::SIZE_HALF, 32'h00000003, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h200, bzram_pkg::SIZE_WORD, 32'h0,        1'b0, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h3FF, bzram_pkg::SIZE_BYTE, 32'h0,        1'b0, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h3FE, bzram_pkg::SIZE_HALF, 32'h0,        1'b0, 32'h0, 1'b0},
    // select masked bank 1 through a byte write
    '{bzram_pkg::OP_WRITE, 10'h00B, bzram_pkg::SIZE_BYTE, 32'hFFFFFF01, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h200, bzram_pkg::SIZE_WORD, 32'h0,        1'b0, 32'h0, 1'b0},
    // enable all banks, select bank 2, size three write
    '{bzram_pkg::OP_WRITE, 10'h008, bzram_pkg::SIZE_WORD, 32'h00000002, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_WRITE, 10'h3FC, bzram_pkg::SIZE_RSVD, 32'hDEADBEEF, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h3FC, bzram_pkg::SIZE_WORD, 32'h0,        1'b0, 32'h0, 1'b0},
    // high byte of the bank select register
    '{bzram_pkg::OP_WRITE, 10'h00A, bzram_pkg::SIZE_BYTE, 32'h000000FE, 1'b1, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h00A, bzram_pkg::SIZE_HALF, 32'h0,        1'b0, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h00B, bzram_pkg::SIZE_BYTE, 32'h0,        1'b0, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h3FD, bzram_pkg::SIZE_BYTE, 32'h0,        1'b0, 32'h0, 1'b0},
    '{bzram_pkg::OP_READ,  10'h1FF, bzram_pkg::SIZE_BYTE, 32'h0,        1'b1, 32'h0, 1'b1}
  };

  banked_zone_ram_with_attr_regs_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // apply one access to the model stores and return its result item
  function automatic void apply_bus_access(input logic op, input logic [9:0] off,
                                           input logic [1:0] sz, input logic [31:0] wd_in,
                                           output access_result_t res);
    int          nbytes;
    int          sh;
    logic [9:0]  addr;
    logic [31:0] smask;
    logic [31:0] wd;
    logic [31:0] lmask;
    logic [2:0]  unit;
    logic [2:0]  unit_lo;
    logic [6:0]  row;
    logic [1:0]  sel;
    unique case (sz)
      bzram_pkg::SIZE_BYTE: nbytes = 1;
      bzram_pkg::SIZE_HALF: nbytes = 2;
      default:              nbytes = 4;
    endcase
    smask = (nbytes == 4) ? 32'hFFFFFFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
    addr  = off & ~10'(nbytes - 1);
    wd    = wd_in & smask;
    res.read_data = '0;
    res.unmapped  = 1'b0;

    if (addr < ATTR_END) begin
      // attribute area, big-endian: even offset is the high byte
      unit = addr[3:1];
      if (nbytes == 4) begin
        unit_lo = unit + 3'd1;
        if (op == bzram_pkg::OP_WRITE) begin
          attr_q[unit]    = wd[31:16];
          attr_q[unit_lo] = wd[15:0];
        end else begin
          res.read_data = {attr_q[unit], attr_q[unit_lo]};
        end
      end else if (nbytes == 2) begin
        if (op == bzram_pkg::OP_WRITE) attr_q[unit] = wd[15:0];
        else res.read_data = {16'h0, attr_q[unit]};
      end else begin
        sh = addr[0] ? 0 : 8;
        if (op == bzram_pkg::OP_WRITE) begin
          attr_q[unit] = (attr_q[unit] & ~(16'h00FF << sh)) | (16'(wd[7:0]) << sh);
        end else begin
          res.read_data = {24'h0, 8'(attr_q[unit] >> sh)};
        end
      end
    end else if (addr >= RAM_BASE) begin
      // bank ram, lanes taken from the enclosing word
      row   = addr[8:2];
      sh    = (4 - int'(addr[1:0]) - nbytes) * 8;
      lmask = smask << sh;
      if (op == bzram_pkg::OP_WRITE) begin
        for (int b = 0; b < bzram_pkg::NUM_BANKS_DEF; b++) begin
          if (attr_q[bzram_pkg::ATTR_BANK_WEN][4*b] == 1'b0) begin
            ram_q[b][row] = (ram_q[b][row] & ~lmask) | ((wd << sh) & lmask);
          end
        end
      end else begin
        sel = attr_q[bzram_pkg::ATTR_BANK_SEL][1:0];
        if (int'(sel) < bzram_pkg::NUM_BANKS_DEF) begin
          res.read_data = (ram_q[sel][row] >> sh) & smask;
        end
      end
    end else begin
      res.unmapped = 1'b1;
    end

    if (op == bzram_pkg::OP_WRITE) res.read_data = '0;
  endfunction

  // offsets biased toward the areas and toward a few hot ram rows
  function automatic logic [9:0] pick_offset();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 10'($urandom_range(0, 15));
    if (roll < 70) begin
      if ($urandom_range(0, 1) == 0) begin
        return RAM_BASE | 10'($urandom_range(0, 15)) | 10'($urandom_range(0, 1) * 10'h1F0);
      end
      return RAM_BASE | 10'($urandom_range(0, 511));
    end
    if (roll < 85) return 10'($urandom_range(16, 511));
    return 10'($urandom_range(0, 1023));
  endfunction

  // hand one access to the unit and record its result item at the accept edge
  task automatic issue_access(input logic op, input logic [9:0] off, input logic [1:0] sz,
                              input logic [31:0] wd, input logic pin,
                              input access_result_t pinned);
    access_result_t outcome;
    if (sender_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, wd, sz, off};
    do @(posedge clk); while (!in_tready);
    apply_bus_access(op, off, sz, wd, outcome);
    access_results_due.push_back(pin ? pinned : outcome);
    if (op == bzram_pkg::OP_WRITE) n_writes++;
    else n_reads++;
    if (outcome.unmapped) n_outside++;
    @(negedge clk);
  endtask

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result item with the oldest one due
  always @(posedge clk) begin
    access_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (access_results_due.size() == 0) begin
        $display("%0t: unexpected result item: read_data %08h unmapped %0b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        due = access_results_due.pop_front();
        n_checked++;
        if (out_tdata !== due.read_data) begin
          $display("%0t: read_data expected %08h got %08h", $time, due.read_data, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== due.unmapped) begin
          $display("%0t: unmapped expected %0b got %0b", $time, due.unmapped, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, access_results_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int             issued;
    int             next_mode_at;
    int             mode;
    logic           op;
    logic [9:0]     off;
    logic [1:0]     sz;
    logic [31:0]    wd;
    access_result_t none;
    none = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed accesses
    foreach (directed_rows[i]) begin
      issue_access(directed_rows[i].op, directed_rows[i].offset, directed_rows[i].size_code,
                   directed_rows[i].write_data, directed_rows[i].pinned,
                   '{directed_rows[i].pin_data, directed_rows[i].pin_unmapped});
    end

    // random accesses, often a write followed by a read at the same offset
    issued       = 0;
    next_mode_at = 0;
    while (issued < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - issued <= CALM_ITEMS) begin
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
      end else if (issued >= next_mode_at) begin
        mode         = $urandom_range(0, 3);
        sender_idle  = mode[0];
        sink_idle    = mode[1];
        next_mode_at = issued + 150;
      end
      off = pick_offset();
      sz  = 2'($urandom_range(0, 3));
      wd  = $urandom;
      if ($urandom_range(0, 9) < 4) begin
        issue_access(bzram_pkg::OP_WRITE, off, sz, wd, 1'b0, none);
        issue_access(bzram_pkg::OP_READ, off, 2'($urandom_range(0, 3)), $urandom, 1'b0, none);
        issued += 2;
      end else begin
        op = 1'($urandom_range(0, 1));
        issue_access(op, off, sz, wd, 1'b0, none);
        issued++;
      end
    end
    in_tvalid <= 1'b0;

    // drain, then watch for any stray item
    while (access_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d reads and %0d writes, %0d of them outside both areas",
             n_reads, n_writes, n_outside);
    $display("%0d result items checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
